// ===== hw/rtl/vabe_pkg.sv =====
package vabe_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		KIND_DRAW   = 2'd0,
		KIND_MOVE   = 2'd1,
		KIND_FORGET = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	// Byte slots in send order
	localparam int SLOT_GS    = 0;
	localparam int SLOT_HI_Y  = 1;
	localparam int SLOT_EXTRA = 2;
	localparam int SLOT_LO_Y  = 3;
	localparam int SLOT_HI_X  = 4;
	localparam int SLOT_LO_X  = 5;
	localparam int NUM_SLOTS  = 6;

	localparam logic [7:0] BYTE_GS   = 8'o035;
	localparam logic [7:0] BYTE_NUL  = 8'h00;
	localparam logic [7:0] TAG_HI    = 8'o040;
	localparam logic [7:0] TAG_LOY   = 8'o140;
	localparam logic [7:0] TAG_LOX   = 8'o100;

	localparam logic [9:0]  SCALE_MUL = 10'd780;
	localparam logic [11:0] BIAS_FLIP = 12'h800;

	// One point's worth of bytes to send
	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [4:0]           hi_y;
		logic [3:0]           extra;
		logic [4:0]           lo_y;
		logic [4:0]           hi_x;
		logic [4:0]           lo_x;
		logic [2:0]           pad;
	} desc_t;

	// (v + 2048) * 780 / 1024, truncated
	function automatic logic [11:0] scale_coord(input logic [11:0] raw);
		logic [21:0] prod;
		prod = 22'(raw ^ BIAS_FLIP) * 22'(SCALE_MUL);
		return prod[21:10];
	endfunction

	// Distance between high parts; an unknown previous value counts as -1
	function automatic logic [5:0] hi_dist(input logic [4:0] cur, input logic [4:0] prev,
			input logic known);
		logic [5:0] d;
		if (!known) begin
			d = 6'(cur) + 6'd1;
		end else if (cur > prev) begin
			d = 6'(cur - prev);
		end else begin
			d = 6'(prev - cur);
		end
		return d;
	endfunction

endpackage

// ===== hw/rtl/vabe_front.sv =====
module vabe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,
	input  logic [1:0]           s_axis_tuser,
	output logic                 push_valid,
	input  logic                 push_ready,
	output vabe_pkg::desc_t      push_desc
);

	logic                  valid_s1;
	vabe_pkg::kind_t       kind_s1;
	logic [11:0]           sx_s1;
	logic [11:0]           sy_s1;

	logic [4:0]            prev_hi_y_q;
	logic [4:0]            prev_hi_x_q;
	logic [4:0]            prev_lo_y_q;
	logic [3:0]            prev_extra_q;
	logic                  prev_known_q;

	logic                  is_point;
	logic                  is_forget;
	logic                  consume;
	logic                  in_accept;
	logic [4:0]            hi_x, hi_y, lo_x, lo_y;
	logic [3:0]            extra;
	logic                  chg_hi_y, chg_hi_x, chg_lo_y, chg_ext;
	logic [6:0]            dist_sum;
	logic [2:0]            pad;

	always_comb begin
		is_point  = 1'b0;
		is_forget = 1'b0;
		unique case (kind_s1)
			vabe_pkg::KIND_DRAW, vabe_pkg::KIND_MOVE: is_point = 1'b1;
			vabe_pkg::KIND_FORGET:                    is_forget = 1'b1;
			default:                                  ;
		endcase
	end

	// Retire the stage-1 item; points need room in the queue
	assign consume       = valid_s1 && (!is_point || push_ready);
	assign s_axis_tready = !valid_s1 || consume;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1 <= vabe_pkg::kind_t'(s_axis_tuser);
			sx_s1   <= vabe_pkg::scale_coord(s_axis_tdata[11:0]);
			sy_s1   <= vabe_pkg::scale_coord(s_axis_tdata[23:12]);
		end
	end

	// Split scaled coordinates into address fields
	assign hi_x  = sx_s1[11:7];
	assign hi_y  = sy_s1[11:7];
	assign lo_x  = sx_s1[6:2];
	assign lo_y  = sy_s1[6:2];
	assign extra = {sy_s1[1:0], sx_s1[1:0]};

	assign chg_hi_y = !prev_known_q || (hi_y != prev_hi_y_q);
	assign chg_hi_x = !prev_known_q || (hi_x != prev_hi_x_q);
	assign chg_lo_y = !prev_known_q || (lo_y != prev_lo_y_q);
	assign chg_ext  = !prev_known_q || (extra != prev_extra_q);

	assign dist_sum = 7'(vabe_pkg::hi_dist(hi_x, prev_hi_x_q, prev_known_q))
		+ 7'(vabe_pkg::hi_dist(hi_y, prev_hi_y_q, prev_known_q)) + 7'd6;

	// Divide by twelve; the sum never exceeds 56
	always_comb begin
		if (dist_sum >= 7'd48) begin
			pad = 3'd4;
		end else if (dist_sum >= 7'd36) begin
			pad = 3'd3;
		end else if (dist_sum >= 7'd24) begin
			pad = 3'd2;
		end else if (dist_sum >= 7'd12) begin
			pad = 3'd1;
		end else begin
			pad = 3'd0;
		end
	end

	always_comb begin
		push_desc = '0;
		push_desc.mask[vabe_pkg::SLOT_GS]    = (kind_s1 == vabe_pkg::KIND_MOVE);
		push_desc.mask[vabe_pkg::SLOT_HI_Y]  = chg_hi_y;
		push_desc.mask[vabe_pkg::SLOT_EXTRA] = chg_ext;
		push_desc.mask[vabe_pkg::SLOT_LO_Y]  = chg_hi_x || chg_ext || chg_lo_y;
		push_desc.mask[vabe_pkg::SLOT_HI_X]  = chg_hi_x;
		push_desc.mask[vabe_pkg::SLOT_LO_X]  = 1'b1;
		push_desc.hi_y  = hi_y;
		push_desc.extra = extra;
		push_desc.lo_y  = lo_y;
		push_desc.hi_x  = hi_x;
		push_desc.lo_x  = lo_x;
		push_desc.pad   = pad;
	end

	assign push_valid = valid_s1 && is_point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_known_q <= 1'b0;
			prev_hi_y_q  <= '0;
			prev_hi_x_q  <= '0;
			prev_lo_y_q  <= '0;
			prev_extra_q <= '0;
		end else if (consume) begin
			if (is_point) begin
				prev_known_q <= 1'b1;
				prev_hi_y_q  <= hi_y;
				prev_hi_x_q  <= hi_x;
				prev_lo_y_q  <= lo_y;
				prev_extra_q <= extra;
			end else if (is_forget) begin
				prev_known_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/vabe_fifo.sv =====
module vabe_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  vabe_pkg::desc_t push_desc,
	output logic            head_valid,
	input  logic            pop,
	output vabe_pkg::desc_t head_desc
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	vabe_pkg::desc_t entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_desc  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/vabe_back.sv =====
module vabe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  vabe_pkg::desc_t head_desc,
	output logic            pop,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [7:0]      m_axis_tdata,
	output logic            m_axis_tlast
);

	logic                  cur_valid_q;
	vabe_pkg::desc_t       cur_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;

	logic                  out_free, emit, done;
	logic [7:0]            sel_byte;
	logic [vabe_pkg::NUM_SLOTS-1:0] mask_next;
	logic [2:0]            pad_next;

	assign out_free = !out_valid_q || m_axis_tready;
	assign emit     = cur_valid_q && out_free;

	// Send the lowest pending slot, then the NUL padding
	always_comb begin
		mask_next = cur_q.mask & (cur_q.mask - 1'b1);
		pad_next  = cur_q.pad;
		if (cur_q.mask[vabe_pkg::SLOT_GS]) begin
			sel_byte = vabe_pkg::BYTE_GS;
		end else if (cur_q.mask[vabe_pkg::SLOT_HI_Y]) begin
			sel_byte = vabe_pkg::TAG_HI | 8'(cur_q.hi_y);
		end else if (cur_q.mask[vabe_pkg::SLOT_EXTRA]) begin
			sel_byte = vabe_pkg::TAG_LOY | 8'(cur_q.extra);
		end else if (cur_q.mask[vabe_pkg::SLOT_LO_Y]) begin
			sel_byte = vabe_pkg::TAG_LOY | 8'(cur_q.lo_y);
		end else if (cur_q.mask[vabe_pkg::SLOT_HI_X]) begin
			sel_byte = vabe_pkg::TAG_HI | 8'(cur_q.hi_x);
		end else if (cur_q.mask[vabe_pkg::SLOT_LO_X]) begin
			sel_byte = vabe_pkg::TAG_LOX | 8'(cur_q.lo_x);
		end else begin
			sel_byte = vabe_pkg::BYTE_NUL;
			pad_next = cur_q.pad - 3'd1;
		end
	end

	assign done = (mask_next == '0) && (pad_next == '0);
	assign pop  = head_valid && (!cur_valid_q || (emit && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
		end else if (emit && done) begin
			cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_desc;
		end else if (emit) begin
			cur_q.mask <= mask_next;
			cur_q.pad  <= pad_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= sel_byte;
			out_last_q <= done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== hw/rtl/vector_address_byte_encoder.sv =====
// Vector address byte encoder: turns signed 12-bit screen points into the
// byte stream of a 12-bit terminal vector address.
// Input channel s_axis: one beat per point. tuser holds the kind (draw,
// move with dark-vector prefix, forget the last address); tdata holds
// x_coord in bits 11:0 and y_coord in bits 23:12, both two's complement.
// Output channel m_axis: one byte per beat, tlast high on the final byte
// caused by a point. A point yields one to ten bytes; forget and unused
// kinds yield none.
// Path: a point's input beat loads the scale stage; the point is then
// written into the queue, loaded into the byte sequencer and put in
// the output register, from which its first byte shows on m_axis.
// Throughput: the byte sequencer sends one byte per cycle while the
// receiver does not stall; the input side takes a beat every cycle
// while the queue has room.
// Reset clears the pipeline, the queue and the known-address flag, so the
// first point after reset sends every field. When the receiver stalls,
// the output beat holds, the sequencer waits and the queue fills; once it
// is full the input stops taking beats.
module vector_address_byte_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // x_coord [11:0], y_coord [23:12]
	input  logic [1:0]  s_axis_tuser,   // kind [1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
	output logic        m_axis_tlast
);

	logic            push_valid, push_ready;
	vabe_pkg::desc_t push_desc;
	logic            head_valid, pop;
	vabe_pkg::desc_t head_desc;

	// Scale, split and compare against the last address sent
	vabe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_desc     (push_desc)
	);

	// Hold classified points so each side can stall on its own
	vabe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.head_valid (head_valid),
		.pop        (pop),
		.head_desc  (head_desc)
	);

	// Expand each point into its bytes, one beat per cycle while m_axis is ready
	vabe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_desc     (head_desc),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== hw/rtl/vabe_checker.sv =====
module vabe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);

	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// A point ends on its low-x byte or on padding
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
		(m_axis_tdata == 8'h00) || (m_axis_tdata[7:5] == 3'b010))
		else $error("final byte is neither low x nor padding");

	// Bytes of one point leave without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a point's byte run");

	// A new point never starts with padding
	a_no_lead_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
		!(m_axis_tvalid && (m_axis_tdata == 8'h00)))
		else $error("point started with a padding byte");

endmodule

bind vector_address_byte_encoder vabe_checker u_vabe_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	// Wait after draining, so a stray byte would still be caught
	localparam int SETTLE_CYCLES = 16;
	// Abort limit for a hung run
	localparam int CYCLE_LIMIT   = 500000;
	localparam int MAX_BYTES     = 10;

	// One output beat as the encoder should send it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_beat_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;                  // x_coord [11:0], y_coord [23:12]
	logic [1:0]  s_axis_tuser  = vabe_pkg::KIND_DRAW; // kind [1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;                        // out_byte [7:0]
	logic        m_axis_tlast;

	// Bytes still owed by the encoder, oldest first
	enc_beat_t   pending_bytes[$];

	// Address fields last sent, as the encoder should remember them
	logic [4:0]  sent_hi_y   = '0;
	logic [4:0]  sent_hi_x   = '0;
	logic [4:0]  sent_lo_y   = '0;
	logic [3:0]  sent_extra  = '0;
	logic        sent_known  = 1'b0;

	// Last draw or move point taken; random steps start from here
	logic [11:0] cur_x       = '0;
	logic [11:0] cur_y       = '0;

	int          idle_pct    = 0;
	int          stall_pct   = 0;
	int          error_count = 0;
	int          cycle_count = 0;

	vector_address_byte_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL vector_address_byte_encoder");
			$finish;
		end
	end

	// Receiver: stall at random, at the rate the current test asks for
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare every accepted byte with the oldest one owed
	always @(posedge clk) begin
		enc_beat_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected beat: out_byte %03o last %0b", m_axis_tdata, m_axis_tlast);
				error_count++;
			end else begin
				want = pending_bytes.pop_front();
				if (m_axis_tdata !== want.data) begin
					$error("out_byte: expected %03o, got %03o", want.data, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	// Map a signed screen coordinate onto 0..3119 terminal units
	function automatic logic [11:0] screen_units(input logic signed [11:0] v);
		int s;
		s = ((int'(v) + 2048) * 780) / 1024;
		return s[11:0];
	endfunction

	// Work out the bytes one accepted point should produce and update the
	// remembered address
	function automatic void encode_point(input vabe_pkg::kind_t k, input logic [11:0] x,
			input logic [11:0] y);
		logic [11:0] sx, sy;
		logic [4:0]  hx, hy, lx, ly;
		logic [3:0]  ext;
		int          ox, oy, dx, dy, pad;
		logic [7:0]  seq[$];
		if (k == vabe_pkg::KIND_FORGET) begin
			sent_known = 1'b0;
			return;
		end
		if (k == vabe_pkg::KIND_UNUSED) begin
			return;
		end
		sx  = screen_units(x);
		sy  = screen_units(y);
		hx  = sx[11:7];
		hy  = sy[11:7];
		lx  = sx[6:2];
		ly  = sy[6:2];
		ext = {sy[1:0], sx[1:0]};

		// An unknown previous high part counts as -1 for the padding
		ox  = sent_known ? int'(sent_hi_x) : -1;
		oy  = sent_known ? int'(sent_hi_y) : -1;
		dx  = int'(hx) - ox;
		dy  = int'(hy) - oy;
		if (dx < 0) begin
			dx = -dx;
		end
		if (dy < 0) begin
			dy = -dy;
		end
		pad = (dx + dy + 6) / 12;

		if (k == vabe_pkg::KIND_MOVE) begin
			seq.push_back(vabe_pkg::BYTE_GS);
		end
		if (!sent_known || hy != sent_hi_y) begin
			seq.push_back(vabe_pkg::TAG_HI | hy);
		end
		if (!sent_known || hx != sent_hi_x) begin
			if (!sent_known || ext != sent_extra) begin
				seq.push_back(vabe_pkg::TAG_LOY | ext);
			end
			seq.push_back(vabe_pkg::TAG_LOY | ly);
			seq.push_back(vabe_pkg::TAG_HI | hx);
		end else if (ext != sent_extra) begin
			seq.push_back(vabe_pkg::TAG_LOY | ext);
			seq.push_back(vabe_pkg::TAG_LOY | ly);
		end else if (ly != sent_lo_y) begin
			seq.push_back(vabe_pkg::TAG_LOY | ly);
		end
		seq.push_back(vabe_pkg::TAG_LOX | lx);
		while (pad > 0 && seq.size() < MAX_BYTES) begin
			seq.push_back(vabe_pkg::BYTE_NUL);
			pad--;
		end
		foreach (seq[i]) begin
			pending_bytes.push_back('{data: seq[i], last: (i == seq.size() - 1)});
		end

		sent_hi_y  = hy;
		sent_hi_x  = hx;
		sent_lo_y  = ly;
		sent_extra = ext;
		sent_known = 1'b1;
	endfunction

	// Drive one point and hold it until the encoder takes it. Enter and
	// leave at a falling edge; valid stays high for a back-to-back point.
	task automatic send_point(input vabe_pkg::kind_t k, input logic [11:0] x,
			input logic [11:0] y);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, x};
		s_axis_tuser  <= k;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		encode_point(k, x, y);
		if (k == vabe_pkg::KIND_DRAW || k == vabe_pkg::KIND_MOVE) begin
			cur_x = x;
			cur_y = y;
		end
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed byte has come out, then a
	// little longer so a stray byte would still be caught
	task automatic drain_output();
		s_axis_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [11:0] edge_coord();
		case ($urandom_range(3))
			0:       return 12'h800;
			1:       return 12'h7FF;
			2:       return 12'h000;
			default: return 12'hFFF;
		endcase
	endfunction

	// Step a coordinate: mostly small moves that touch only the low fields,
	// sometimes a jump across a high-part boundary, sometimes no move
	function automatic logic [11:0] step_coord(input logic [11:0] base);
		case ($urandom_range(3))
			0:       return base;
			1:       return base + 12'(int'($urandom_range(8)) - 4);
			2:       return base + 12'(int'($urandom_range(320)) - 160);
			default: return base + 12'(int'($urandom_range(2)) - 1);
		endcase
	endfunction

	// Random point: mostly draws and moves near the last one, some far
	// jumps and edges, a few forgets and unused kinds. Report whether the
	// encoder does anything with it.
	task automatic send_random_point(output bit counted);
		int              roll;
		vabe_pkg::kind_t k;
		logic [11:0]     x, y;
		roll = $urandom_range(99);
		k    = ($urandom_range(1) == 1) ? vabe_pkg::KIND_MOVE : vabe_pkg::KIND_DRAW;
		if (roll < 6) begin
			k = vabe_pkg::KIND_FORGET;
		end else if (roll < 9) begin
			k = vabe_pkg::KIND_UNUSED;
		end
		roll = $urandom_range(99);
		if (roll < 30) begin
			x = 12'($urandom);
			y = 12'($urandom);
		end else if (roll < 90) begin
			x = step_coord(cur_x);
			y = step_coord(cur_y);
		end else begin
			x = edge_coord();
			y = edge_coord();
		end
		send_point(k, x, y);
		counted = (k != vabe_pkg::KIND_UNUSED);
	endtask

	task automatic run_random(input int n, input int idle, input int stall);
		int sent;
		bit counted;
		idle_pct  = idle;
		stall_pct = stall;
		sent      = 0;
		while (sent < n) begin
			send_random_point(counted);
			if (counted) begin
				sent++;
			end
		end
		drain_output();
	endtask

	// Edges of the coordinate range, every kind, repeated points, forget,
	// the unused kind and the longest padding
	task automatic test_corner_points();
		idle_pct  = 0;
		stall_pct = 0;
		// First point after reset sends every field
		send_point(vabe_pkg::KIND_DRAW,   12'h800, 12'h800);
		// Far corner with the dark-vector prefix: ten bytes
		send_point(vabe_pkg::KIND_MOVE,   12'h7FF, 12'h7FF);
		// Same point again: only the low x byte
		send_point(vabe_pkg::KIND_DRAW,   12'h7FF, 12'h7FF);
		// Unused kind leaves the address alone
		send_point(vabe_pkg::KIND_UNUSED, 12'h000, 12'h000);
		send_point(vabe_pkg::KIND_DRAW,   12'h7FF, 12'h7FF);
		// Forget, then the same point: every field, padding from unknown
		send_point(vabe_pkg::KIND_FORGET, 12'h123, 12'h456);
		send_point(vabe_pkg::KIND_MOVE,   12'h7FF, 12'h7FF);
		send_point(vabe_pkg::KIND_FORGET, 12'h000, 12'h000);
		send_point(vabe_pkg::KIND_FORGET, 12'hFFF, 12'hFFF);
		send_point(vabe_pkg::KIND_DRAW,   12'h800, 12'h800);
		// Step through the fields in turn: extra, low y, high x, high y
		send_point(vabe_pkg::KIND_DRAW,   12'd0,   12'd0);
		send_point(vabe_pkg::KIND_DRAW,   12'd0,   12'd2);
		send_point(vabe_pkg::KIND_DRAW,   12'd0,   12'd6);
		send_point(vabe_pkg::KIND_DRAW,   12'd137, 12'd6);
		send_point(vabe_pkg::KIND_DRAW,   12'd137, 12'd300);
		send_point(vabe_pkg::KIND_MOVE,   12'd137, 12'd300);
		// Bit patterns and values near zero
		send_point(vabe_pkg::KIND_DRAW,   12'hFFF, 12'hFFF);
		send_point(vabe_pkg::KIND_DRAW,   12'h555, 12'hAAA);
		send_point(vabe_pkg::KIND_MOVE,   12'hAAA, 12'h555);
		send_point(vabe_pkg::KIND_DRAW,   12'h001, 12'hFFE);
		send_point(vabe_pkg::KIND_MOVE,   12'h800, 12'h7FF);
		send_point(vabe_pkg::KIND_DRAW,   12'h7FF, 12'h800);
		drain_output();
	endtask

	// Let the encoder run dry mid-stream, then pick up again
	task automatic test_drain_pause();
		bit counted;
		idle_pct  = 0;
		stall_pct = 50;
		repeat (8) send_random_point(counted);
		drain_output();
		repeat (8) send_random_point(counted);
		drain_output();
	endtask

	task automatic test_steady_stream();
		run_random(90, 0, 0);
	endtask

	task automatic test_sparse_sender();
		run_random(80, 86, 0);
	endtask

	task automatic test_stalled_receiver();
		run_random(80, 0, 86);
	endtask

	task automatic test_mixed_idling();
		run_random(80, 19, 19);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_corner_points();
		test_steady_stream();
		test_drain_pause();
		test_sparse_sender();
		test_stalled_receiver();
		test_mixed_idling();

		if (error_count == 0) begin
			$display("PASS vector_address_byte_encoder");
		end else begin
			$display("FAIL vector_address_byte_encoder");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/vabe_pkg.sv
hw/rtl/vabe_front.sv
hw/rtl/vabe_fifo.sv
hw/rtl/vabe_back.sv
hw/rtl/vector_address_byte_encoder.sv
hw/rtl/vabe_checker.sv
sim/tb.sv
